FILE: design/rtwc_pkg.sv
// shared types and constants for the route time window checker
// stop and result transaction layouts, per-route state and fail codes
// no dependencies
package rtwc_pkg;

  localparam int NODE_W   = 10;
  localparam int TRAVEL_W = 24;
  localparam int WHOLE_W  = 16;
  localparam int FRAC_W   = 8;
  localparam int CLOCK_W  = 32;
  localparam int LOAD_W   = 24;
  localparam int DEMAND_W = 16;
  localparam int CAP_W    = 16;

  localparam logic [NODE_W-1:0] DEPOT_NODE_DEFAULT = '0;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET     = '1;

  typedef enum logic [1:0] {
    REASON_OK    = 2'd0,
    REASON_DEPOT = 2'd1,
    REASON_LATE  = 2'd2,
    REASON_CAP   = 2'd3
  } reason_t;

  typedef struct packed {
    logic [NODE_W-1:0]   stop_node;
    logic [TRAVEL_W-1:0] travel_ticks;
    logic [WHOLE_W-1:0]  window_open;
    logic [WHOLE_W-1:0]  window_close;
    logic [WHOLE_W-1:0]  service_duration;
    logic [DEMAND_W-1:0] stop_demand;
    logic                last_stop;
  } stop_t;

  typedef struct packed {
    logic               feasible;
    logic [1:0]         fail_reason;
    logic [CLOCK_W-1:0] finish_time;
    logic [LOAD_W-1:0]  total_load;
  } result_t;

  typedef struct packed {
    logic [CLOCK_W-1:0] clock_time;
    logic [LOAD_W-1:0]  load_sum;
    logic               route_open;
    logic               start_was_depot;
    reason_t            first_failure;
  } route_state_t;

endpackage

FILE: design/rtwc_step.sv
// one stop of the route check: next route state and the result for a last stop
// purely combinational, sits between the stop register and the result register
// depends on rtwc_pkg
module rtwc_step
  import rtwc_pkg::*;
#(
  parameter logic [NODE_W-1:0] DEPOT_NODE = DEPOT_NODE_DEFAULT
) (
  input  stop_t             stop,
  input  route_state_t      state,
  input  logic [CAP_W-1:0]  capacity,
  output route_state_t      state_next,
  output result_t           result
);

  logic                 is_depot;
  logic [CLOCK_W:0]     arrive_sum;
  logic [CLOCK_W-1:0]   arrive;
  logic [CLOCK_W-1:0]   open_t;
  logic [CLOCK_W-1:0]   close_t;
  logic [CLOCK_W-1:0]   start_t;
  logic [CLOCK_W:0]     depart_sum;
  logic [CLOCK_W-1:0]   depart;
  logic [LOAD_W:0]      load_add;
  logic [LOAD_W-1:0]    load_new;
  logic                 late;
  reason_t              reason;

  always_comb begin
    is_depot = (stop.stop_node == DEPOT_NODE);
    open_t   = {{(CLOCK_W-WHOLE_W-FRAC_W){1'b0}}, stop.window_open, {FRAC_W{1'b0}}};
    close_t  = {{(CLOCK_W-WHOLE_W-FRAC_W){1'b0}}, stop.window_close, {FRAC_W{1'b0}}};

    // travel, then wait for the window to open
    arrive_sum = {1'b0, state.clock_time}
               + {{(CLOCK_W+1-TRAVEL_W){1'b0}}, stop.travel_ticks};
    arrive     = arrive_sum[CLOCK_W] ? '1 : arrive_sum[CLOCK_W-1:0];
    start_t    = (arrive < open_t) ? open_t : arrive;
    late       = (start_t > close_t);

    // service and delivery
    depart_sum = {1'b0, start_t}
               + {{(CLOCK_W+1-WHOLE_W-FRAC_W){1'b0}}, stop.service_duration, {FRAC_W{1'b0}}};
    depart     = depart_sum[CLOCK_W] ? '1 : depart_sum[CLOCK_W-1:0];
    load_add   = {1'b0, state.load_sum}
               + {{(LOAD_W+1-DEMAND_W){1'b0}}, stop.stop_demand};
    load_new   = load_add[LOAD_W] ? '1 : load_add[LOAD_W-1:0];

    state_next = state;
    if (!state.route_open) begin
      state_next.clock_time      = '0;
      state_next.load_sum        = '0;
      state_next.first_failure   = REASON_OK;
      state_next.start_was_depot = is_depot;
      state_next.route_open      = 1'b1;
    end else if (state.first_failure == REASON_OK) begin
      if (late) begin
        state_next.clock_time    = start_t;
        state_next.first_failure = REASON_LATE;
      end else begin
        state_next.clock_time = depart;
        state_next.load_sum   = load_new;
        if (load_new > {{(LOAD_W-CAP_W){1'b0}}, capacity}) begin
          state_next.first_failure = REASON_CAP;
        end else if (stop.last_stop && (depart > close_t)) begin
          // the closing depot is checked again after its service
          state_next.first_failure = REASON_LATE;
        end
      end
    end

    // route closes on its last stop
    if (stop.last_stop) begin
      state_next.route_open = 1'b0;
    end

    reason = (!state_next.start_was_depot || !is_depot) ? REASON_DEPOT
                                                         : state_next.first_failure;
    result.feasible    = (reason == REASON_OK);
    result.fail_reason = reason;
    result.finish_time = state_next.clock_time;
    result.total_load  = state_next.load_sum;
  end

endmodule

FILE: design/route_time_window_checker.sv
// top level of the route time window checker
// stop register, route state, result register; uses rtwc_step
// depends on rtwc_pkg
//
// usage
//   stops of one route arrive in order on the stop channel (stop_valid,
//   stop_stall, stop). the first stop opens a route, the one flagged
//   last_stop closes it and produces one transaction on the result channel
//   (result_valid, result_stall, result). other stops produce nothing.
//   capacity is written through cfg_we / cfg_wdata while the block is idle.
// throughput and pipeline
//   one stop per cycle while stop_stall is low. a stop accepted into the stop
//   register waits there while rtwc_step forms its route update and result;
//   both are registered when the stop advances, so result_valid rises once
//   the closing stop leaves the stop register. the rate is set by the route
//   state loop: add, max, compare, add, compare.
// reset
//   rst (synchronous) empties both registers, closes any open route and sets
//   capacity to its full value 65535.
// stall
//   a held result stays stable while result_stall is high. ordinary stops keep
//   flowing; a closing stop waits in the stop register until the result slot
//   frees, and stop_stall rises while it waits.
module route_time_window_checker
  import rtwc_pkg::*;
#(
  parameter logic [NODE_W-1:0] DEPOT_NODE = DEPOT_NODE_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             stop_valid,
  output logic             stop_stall,
  input  stop_t            stop,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  // stop register
  logic         held_valid;
  stop_t        held;

  // route state and configuration
  route_state_t state;
  route_state_t state_next;
  logic [CAP_W-1:0] capacity;

  result_t      step_result;
  logic         slot_free;
  logic         advance;

  rtwc_step #(
    .DEPOT_NODE (DEPOT_NODE)
  ) u_step (
    .stop       (held),
    .state      (state),
    .capacity   (capacity),
    .state_next (state_next),
    .result     (step_result)
  );

  // the result slot is free when empty or being taken this cycle
  assign slot_free  = !result_valid || !result_stall;
  // a held stop moves on unless it closes a route and the slot is busy
  assign advance    = held_valid && (!held.last_stop || slot_free);
  assign stop_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!stop_stall) begin
      held_valid <= stop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stop_stall) begin
      held <= stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.clock_time      <= '0;
      state.load_sum        <= '0;
      state.route_open      <= 1'b0;
      state.start_was_depot <= 1'b0;
      state.first_failure   <= REASON_OK;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && held.last_stop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held.last_stop) begin
      result <= step_result;
    end
  end

endmodule

FILE: verif/route_time_window_checker_tb.sv
// self-checking testbench for route_time_window_checker
// drives stop transactions, predicts route verdicts in-bench, checks each result transaction
// depends on rtwc_pkg and the design top level
module route_time_window_checker_tb
  import rtwc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // depot node of the instance; the block is built with its default
  localparam logic [NODE_W-1:0] DEPOT = DEPOT_NODE_DEFAULT;
  // quiet time after the last owed result, to let the block settle
  localparam int SETTLE_CYCLES = 6;
  // well above the slowest legal run of ~1100 stops under heavy idling
  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst = 1'b1;
  logic             stop_valid = 1'b0;
  logic             stop_stall;
  stop_t            stop = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // verdicts still owed by the block, oldest first
  result_t          verdict_q[$];
  // route state and capacity as the bench believes them to be
  route_state_t     route_model;
  logic [CAP_W-1:0] cap_model;

  int mismatches = 0;
  int stops_taken = 0;
  int cycles = 0;
  // idle percentages for the stop sender and the result receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // remaining cycles of a forced receiver hold-off
  int hold_left = 0;

  route_time_window_checker #(
    .DEPOT_NODE(DEPOT)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .stop_valid  (stop_valid),
    .stop_stall  (stop_stall),
    .stop        (stop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // route predictor: folds one accepted stop into the route state and returns
  // 1 with the verdict when that stop closes the route
  // ---------------------------------------------------------------------------
  function automatic bit advance_route(input stop_t s, output result_t verdict);
    logic [32:0]        t_wide;
    logic [24:0]        l_wide;
    logic [CLOCK_W-1:0] t;
    logic [CLOCK_W-1:0] open_t;
    logic [CLOCK_W-1:0] close_t;
    logic               at_depot;
    reason_t            why;
    // whole-unit times move up to the 8-bit fraction scale
    open_t   = {8'h00, s.window_open, 8'h00};
    close_t  = {8'h00, s.window_close, 8'h00};
    at_depot = (s.stop_node == DEPOT);
    verdict  = '0;
    if (!route_model.route_open) begin
      // first stop: clear the route, only its node counts
      route_model.clock_time      = '0;
      route_model.load_sum        = '0;
      route_model.first_failure   = REASON_OK;
      route_model.start_was_depot = at_depot;
      route_model.route_open      = 1'b1;
    end else if (route_model.first_failure == REASON_OK) begin
      // travel, saturating at the top of the clock
      t_wide = {1'b0, route_model.clock_time} + {9'b0, s.travel_ticks};
      t = t_wide[32] ? '1 : t_wide[31:0];
      // early arrival waits for the window to open
      if (t < open_t) t = open_t;
      route_model.clock_time = t;
      if (t > close_t) begin
        // late: clock frozen at the arrival after the wait
        route_model.first_failure = REASON_LATE;
      end else begin
        t_wide = {1'b0, t} + {9'b0, s.service_duration, 8'h00};
        route_model.clock_time = t_wide[32] ? '1 : t_wide[31:0];
        l_wide = {1'b0, route_model.load_sum} + {9'b0, s.stop_demand};
        route_model.load_sum = l_wide[24] ? '1 : l_wide[23:0];
        if (route_model.load_sum > {8'h00, cap_model}) begin
          route_model.first_failure = REASON_CAP;
        end else if (s.last_stop && route_model.clock_time > close_t) begin
          // closing depot still has to be left before its window closes
          route_model.first_failure = REASON_LATE;
        end
      end
    end
    if (!s.last_stop) return 1'b0;
    // a route not bounded by the depot fails on that, whatever else happened
    why = (!route_model.start_was_depot || !at_depot) ? REASON_DEPOT
                                                      : route_model.first_failure;
    verdict.feasible    = (why == REASON_OK);
    verdict.fail_reason = why;
    verdict.finish_time = route_model.clock_time;
    verdict.total_load  = route_model.load_sum;
    route_model.route_open = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] w16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic stop_t mk_stop(input logic [NODE_W-1:0] node,
                                    input logic [TRAVEL_W-1:0] travel,
                                    input logic [31:0] wopen, input logic [31:0] wclose,
                                    input logic [31:0] svc, input logic [31:0] dem,
                                    input bit last);
    stop_t s;
    s.stop_node        = node;
    s.travel_ticks     = travel;
    s.window_open      = wopen[WHOLE_W-1:0];
    s.window_close     = wclose[WHOLE_W-1:0];
    s.service_duration = svc[WHOLE_W-1:0];
    s.stop_demand      = dem[DEMAND_W-1:0];
    s.last_stop        = last;
    return s;
  endfunction

  // every field full range, every bit free
  function automatic stop_t random_stop();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(stop_t)-1:0];
  endfunction

  function automatic logic [NODE_W-1:0] off_depot();
    logic [31:0] nd;
    nd = $urandom_range(1, 1023);
    return nd[NODE_W-1:0];
  endfunction

  // offer one stop transaction and hold it until the block takes it;
  // valid is left high so back-to-back calls stream without a bubble
  task automatic send_stop(input stop_t s);
    result_t verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      stop_valid <= 1'b0;
      @(posedge clk);
    end
    stop_valid <= 1'b1;
    stop       <= s;
    @(posedge clk);
    // stall sampled here is the value that stood before the edge
    while (stop_stall) @(posedge clk);
    if (advance_route(s, verdict)) verdict_q = {verdict_q, verdict};
    stops_taken++;
  endtask

  // one route with random content; shaped routes mostly stay feasible,
  // wild ones carry full-range fields on every stop
  task automatic drive_route(input bit depot_ends, input bit wild);
    stop_t       s;
    int          n_mid;
    int          est;
    int          open_u;
    int          bad_end;
    logic [31:0] tr;
    logic [31:0] nd;
    n_mid   = $urandom_range(0, 6);
    bad_end = depot_ends ? 0 : $urandom_range(1, 3);
    est     = 0;
    s = random_stop();
    s.stop_node = bad_end[0] ? off_depot() : DEPOT;
    s.last_stop = 1'b0;
    send_stop(s);
    for (int i = 0; i <= n_mid; i++) begin
      if (wild) begin
        s = random_stop();
      end else begin
        tr = $urandom_range(0, 4096);
        s.travel_ticks = tr[TRAVEL_W-1:0];
        est = est + tr / 256;
        open_u = est + $urandom_range(0, 20) - 8;
        s.window_open = w16(open_u);
        if ($urandom_range(9) == 0) begin
          // window already shut on arrival
          s.window_close = w16(est - $urandom_range(1, 10));
        end else begin
          s.window_close = w16(open_u + $urandom_range(0, (i == n_mid) ? 80 : 40));
        end
        s.service_duration = w16($urandom_range(0, 10));
        s.stop_demand      = w16($urandom_range(0, cap_model / 3 + 2));
        if (open_u > est) est = open_u;
        est = est + s.service_duration;
      end
      s.last_stop = (i == n_mid);
      if (i == n_mid) begin
        s.stop_node = bad_end[1] ? off_depot() : DEPOT;
      end else begin
        nd = $urandom_range(0, 1023);
        s.stop_node = nd[NODE_W-1:0];
      end
      send_stop(s);
    end
  endtask

  // end any open route at the depot so the block goes idle
  task automatic close_route();
    if (route_model.route_open) send_stop(mk_stop(DEPOT, 0, 0, 65535, 0, 0, 1'b1));
  endtask

  // drop valid, let every owed verdict come back, then let the pipe settle
  task automatic wait_quiet();
    stop_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // capacity changes only with no route open and nothing in flight
  task automatic set_capacity(input logic [CAP_W-1:0] v);
    close_route();
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_model = v;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: checks each accepted result, then picks next stall
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    result_t want;
    forever begin
      @(posedge clk);
      // handshake values sampled here are those from before the edge
      if (!rst && result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected, expected none actual %0h",
                   $realtime, result);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("feasible", {31'b0, want.feasible}, {31'b0, result.feasible});
          check_field("fail_reason", {30'b0, want.fail_reason}, {30'b0, result.fail_reason});
          check_field("finish_time", want.finish_time, result.finish_time);
          check_field("total_load", {8'b0, want.total_load}, {8'b0, result.total_load});
        end
      end
      // forced hold-off counts down here, otherwise random stalls
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-built routes at the reset capacity: every fail code, the corners
  task automatic test_corner_routes();
    // single-stop route at the depot and away from it
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b1));
    send_stop(mk_stop(1023, 24'hFFFFFF, 65535, 65535, 65535, 65535, 1'b1));
    // early arrival waits for the window, then a clean return
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(5, 3 * 256, 10, 20, 4, 100, 1'b0));
    send_stop(mk_stop(DEPOT, 512, 0, 65535, 0, 0, 1'b1));
    // late arrival, then a stop that must be absorbed
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(7, 24'hFFFFFF, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(9, 100, 65535, 65535, 65535, 65535, 1'b0));
    send_stop(mk_stop(DEPOT, 0, 0, 65535, 0, 0, 1'b1));
    // load exactly at capacity passes, one more unit fails
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(3, 0, 0, 65535, 0, 65535, 1'b0));
    send_stop(mk_stop(4, 0, 0, 65535, 0, 1, 1'b0));
    send_stop(mk_stop(DEPOT, 0, 0, 65535, 0, 0, 1'b1));
    // route ends away from the depot
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(1023, 256, 0, 65535, 3, 7, 1'b1));
    // route starts away from the depot
    send_stop(mk_stop(2, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(DEPOT, 256, 0, 65535, 0, 0, 1'b1));
    // service at the closing depot runs past its window close
    send_stop(mk_stop(DEPOT, 0, 0, 0, 0, 0, 1'b0));
    send_stop(mk_stop(DEPOT, 256, 0, 2, 5, 0, 1'b1));
    // travel, window, service and demand fields at their top values, no demand on the return
    send_stop(mk_stop(DEPOT, 24'hFFFFFF, 65535, 65535, 65535, 65535, 1'b0));
    send_stop(mk_stop(1, 24'hFFFFFF, 65535, 65535, 65535, 65535, 1'b0));
    send_stop(mk_stop(DEPOT, 24'hFFFFFF, 65535, 65535, 65535, 0, 1'b1));
    wait_quiet();
  endtask

  // mostly well-formed routes, some broken at the ends, some noise
  task automatic test_mixed_routes(input int n_stops);
    int first;
    int pick;
    first = stops_taken;
    while (stops_taken - first < n_stops) begin
      pick = $urandom_range(99);
      if (pick < 70) drive_route(1'b1, 1'b0);
      else if (pick < 82) drive_route(1'b0, 1'b0);
      else if (pick < 90) drive_route(1'b1, 1'b1);
      else send_stop(random_stop());
    end
  endtask

  // capacity extremes and a random value, each with a batch of routes
  task automatic test_capacity_settings();
    logic [31:0] rv;
    set_capacity(16'h0000);
    test_mixed_routes(40);
    set_capacity(16'h0001);
    test_mixed_routes(40);
    rv = $urandom_range(2, 65534);
    set_capacity(rv[CAP_W-1:0]);
    test_mixed_routes(40);
    set_capacity(16'hFFFF);
    test_mixed_routes(40);
  endtask

  // receiver holds off for a long stretch while results pile up,
  // the block has to stall its stop channel
  task automatic test_result_backlog();
    stop_t s;
    hold_left = 300;
    repeat (40) begin
      s = random_stop();
      s.stop_node = DEPOT;
      s.last_stop = 1'b1;
      send_stop(s);
    end
    repeat (5) drive_route(1'b1, 1'b0);
    close_route();
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    route_model = '0;
    cap_model   = CAPACITY_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 57;
    test_corner_routes();
    test_capacity_settings();
    test_mixed_routes(270);

    // the other way round
    send_idle_pct = 57;
    recv_idle_pct = 25;
    set_capacity(16'($urandom_range(100, 40000)));
    test_mixed_routes(300);

    // full speed on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(16'hFFFF);
    test_mixed_routes(290);
    test_result_backlog();

    close_route();
    wait_quiet();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: route_time_window_checker.f
design/rtwc_pkg.sv
design/rtwc_step.sv
design/route_time_window_checker.sv
verif/route_time_window_checker_tb.sv
